[rtl/sse_pkg.sv]
// ----------------------------------------------------------------------------
// sse_pkg
// Shared types and codes of the sparse set engine.
// ----------------------------------------------------------------------------
package sse_pkg;

    localparam logic [1:0] OP_TEST   = 2'd0;
    localparam logic [1:0] OP_ADD    = 2'd1;
    localparam logic [1:0] OP_REMOVE = 2'd2;
    localparam logic [1:0] OP_POP    = 2'd3;

    localparam logic [1:0] STAT_OK      = 2'd0;
    localparam logic [1:0] STAT_PRESENT = 2'd1;
    localparam logic [1:0] STAT_ABSENT  = 2'd2;
    localparam logic [1:0] STAT_EMPTY   = 2'd3;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_LOOK,
        ST_EXEC
    } state_t;

endpackage

[rtl/sse_sparse_mem.sv]
// ----------------------------------------------------------------------------
// sse_sparse_mem
// Element-to-slot memory with one registered read port, one write port and
// a valid bit per entry so that unwritten entries read as zero.
// ----------------------------------------------------------------------------
module sse_sparse_mem #(
    parameter int DEPTH = 256,
    parameter int AW    = 8
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          rd_en,
    input  logic [AW-1:0] rd_addr,
    output logic [AW-1:0] rd_data,
    input  logic          wr_en,
    input  logic [AW-1:0] wr_addr,
    input  logic [AW-1:0] wr_data
);

    logic [AW-1:0] mem [DEPTH];
    logic [DEPTH-1:0] vld_reg;
    logic [AW-1:0] rd_data_reg;
    logic          rd_vld_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg    <= '0;
            rd_vld_reg <= 1'b0;
        end
        else
        begin
            if (wr_en)
            begin
                vld_reg[wr_addr] <= 1'b1;
            end
            if (rd_en)
            begin
                rd_vld_reg <= vld_reg[rd_addr];
            end
        end
    end

    assign rd_data = rd_vld_reg ? rd_data_reg : '0;

endmodule

[rtl/sse_dense_mem.sv]
// ----------------------------------------------------------------------------
// sse_dense_mem
// Dense member memory with two registered read ports and one write port.
// ----------------------------------------------------------------------------
module sse_dense_mem #(
    parameter int DEPTH = 256,
    parameter int AW    = 8
) (
    input  logic          clk,
    input  logic          rd_a_en,
    input  logic [AW-1:0] rd_a_addr,
    output logic [AW-1:0] rd_a_data,
    input  logic          rd_b_en,
    input  logic [AW-1:0] rd_b_addr,
    output logic [AW-1:0] rd_b_data,
    input  logic          wr_en,
    input  logic [AW-1:0] wr_addr,
    input  logic [AW-1:0] wr_data
);

    logic [AW-1:0] mem [DEPTH];
    logic [AW-1:0] rd_a_data_reg;
    logic [AW-1:0] rd_b_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_a_en)
        begin
            rd_a_data_reg <= mem[rd_a_addr];
        end
        if (rd_b_en)
        begin
            rd_b_data_reg <= mem[rd_b_addr];
        end
    end

    assign rd_a_data = rd_a_data_reg;
    assign rd_b_data = rd_b_data_reg;

endmodule

[rtl/sparse_set_engine.sv]
// ----------------------------------------------------------------------------
// sparse_set_engine
// Sparse set over element numbers below UNIVERSE_SIZE: test, add, remove, pop.
// ----------------------------------------------------------------------------
// On accept in ST_IDLE the engine reads the slot of the element and the last
// dense member, ST_LOOK reads the dense entry at that slot, and ST_EXEC, once the
// output register is free or read, checks membership, writes the memories back
// for add and remove and loads the result register. The states follow the chain
// of dependent reads through the slot memory and then the dense memory. A new
// request is taken while the previous result still waits in the output register.
// ----------------------------------------------------------------------------
module sparse_set_engine
    import sse_pkg::*;
#(
    parameter int UNIVERSE_SIZE = 256
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [1:0] operation,
    input  logic [7:0] element,
    output logic       out_valid,
    input  logic       out_ready,
    output logic       found,
    output logic [7:0] popped_element,
    output logic [1:0] status,
    output logic [8:0] member_count
);

    localparam int EFF = (UNIVERSE_SIZE < 256) ? UNIVERSE_SIZE : 256;
    localparam int AW  = $clog2(EFF);
    localparam int CW  = $clog2(EFF + 1);

    state_t        state_reg, state_next;
    logic [CW-1:0] count_reg, count_next;
    logic [1:0]    op_reg;
    logic [7:0]    elem_reg;
    logic          univ_reg;

    logic          out_valid_reg, out_valid_next;
    logic          found_reg;
    logic [7:0]    popped_reg;
    logic [1:0]    status_reg;

    logic          accept;
    logic          go;
    logic          exec;

    logic [AW-1:0] slot;
    logic [AW-1:0] dn_a_data;
    logic [AW-1:0] last;
    logic [CW-1:0] count_m1;

    logic          found_c;
    logic [7:0]    popped_c;
    logic [1:0]    status_c;

    logic          sp_wr_en;
    logic [AW-1:0] sp_wr_addr;
    logic [AW-1:0] sp_wr_data;
    logic          dn_wr_en;
    logic [AW-1:0] dn_wr_addr;
    logic [AW-1:0] dn_wr_data;

    assign in_ready = (state_reg == ST_IDLE);
    assign accept   = in_valid && in_ready;
    assign go       = !out_valid_reg || out_ready;
    assign exec     = (state_reg == ST_EXEC) && go;
    assign count_m1 = count_reg - CW'(1);

    sse_sparse_mem #(
        .DEPTH (EFF),
        .AW    (AW)
    ) u_sparse (
        .clk     (clk),
        .rst_n   (rst_n),
        .rd_en   (accept),
        .rd_addr (element[AW-1:0]),
        .rd_data (slot),
        .wr_en   (sp_wr_en),
        .wr_addr (sp_wr_addr),
        .wr_data (sp_wr_data)
    );

    sse_dense_mem #(
        .DEPTH (EFF),
        .AW    (AW)
    ) u_dense (
        .clk       (clk),
        .rd_a_en   (state_reg == ST_LOOK),
        .rd_a_addr (slot),
        .rd_a_data (dn_a_data),
        .rd_b_en   (accept),
        .rd_b_addr (count_m1[AW-1:0]),
        .rd_b_data (last),
        .wr_en     (dn_wr_en),
        .wr_addr   (dn_wr_addr),
        .wr_data   (dn_wr_data)
    );

    always_comb
    begin
        logic is_member;
        is_member  = univ_reg && (CW'(slot) < count_reg) && (dn_a_data == elem_reg[AW-1:0]);
        found_c    = 1'b0;
        popped_c   = '0;
        status_c   = STAT_OK;
        count_next = count_reg;
        sp_wr_en   = 1'b0;
        sp_wr_addr = elem_reg[AW-1:0];
        sp_wr_data = count_reg[AW-1:0];
        dn_wr_en   = 1'b0;
        dn_wr_addr = count_reg[AW-1:0];
        dn_wr_data = elem_reg[AW-1:0];
        case (op_reg)
            OP_TEST:
            begin
                found_c = is_member;
            end
            OP_ADD:
            begin
                found_c = is_member;
                if (!univ_reg)
                begin
                    status_c = STAT_ABSENT;
                end
                else if (is_member)
                begin
                    status_c = STAT_PRESENT;
                end
                else
                begin
                    sp_wr_en   = exec;
                    dn_wr_en   = exec;
                    count_next = count_reg + CW'(1);
                end
            end
            OP_REMOVE:
            begin
                found_c = is_member;
                if (!is_member)
                begin
                    status_c = STAT_ABSENT;
                end
                else
                begin
                    count_next = count_m1;
                    dn_wr_en   = exec;
                    dn_wr_addr = slot;
                    dn_wr_data = last;
                    sp_wr_en   = exec;
                    sp_wr_addr = last;
                    sp_wr_data = slot;
                end
            end
            default:
            begin
                if (count_reg == '0)
                begin
                    status_c = STAT_EMPTY;
                end
                else
                begin
                    count_next = count_m1;
                    popped_c   = 8'(last);
                end
            end
        endcase
    end

    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg;
        if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = ST_LOOK;
                end
            end
            ST_LOOK:
            begin
                state_next = ST_EXEC;
            end
            ST_EXEC:
            begin
                if (go)
                begin
                    state_next     = ST_IDLE;
                    out_valid_next = 1'b1;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            if (exec)
            begin
                count_reg <= count_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op_reg   <= operation;
            elem_reg <= element;
            univ_reg <= (17'(element) < 17'(UNIVERSE_SIZE));
        end
        if (exec)
        begin
            found_reg  <= found_c;
            popped_reg <= popped_c;
            status_reg <= status_c;
        end
    end

    assign out_valid      = out_valid_reg;
    assign found          = found_reg;
    assign popped_element = popped_reg;
    assign status         = status_reg;
    assign member_count   = 9'(count_reg);

`ifndef SYNTHESIS
    a_empty_result: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && status == STAT_EMPTY) |-> (member_count == 9'd0 && popped_element == 8'd0))
        else $error("empty pop result carries a count or element");

    a_present_found: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && status == STAT_PRESENT) |-> found)
        else $error("already-present status without found");

    a_add_grows: assert property (@(posedge clk) disable iff (!rst_n)
        (exec && op_reg == OP_ADD && status_c == STAT_OK)
            |=> (count_reg == CW'($past(count_reg) + CW'(1))))
        else $error("successful add did not grow the member count");
`endif

endmodule
